[hdl/tile_hierarchy_builder_assert.svh]
// Assertion macros for the tile hierarchy builder checker.
// Expects clk and rst in the scope of use.
`ifndef TILE_HIERARCHY_BUILDER_ASSERT_SVH
`define TILE_HIERARCHY_BUILDER_ASSERT_SVH

// same-cycle implication
`define THB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tile hierarchy builder check failed");

// next-cycle implication
`define THB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tile hierarchy builder check failed");

`endif

[hdl/thb_pkg.sv]
// Shared types and constants of the tile hierarchy builder.
// No dependencies.
`default_nettype none
package thb_pkg;

  localparam int unsigned DIM_W        = 15;
  localparam int unsigned TILE_W       = 11;
  localparam int unsigned PX_W         = 25;
  localparam int unsigned BORDER_W     = 14;
  localparam int unsigned LOG_W        = 4;
  localparam int unsigned EXP_W        = 9;
  localparam int unsigned RESULT_LIMIT = 29;
  localparam logic [LOG_W-1:0] BRANCH_LOG2_MIN = 4'd1;
  localparam logic [LOG_W-1:0] BRANCH_LOG2_MAX = 4'd10;

  typedef struct packed {
    logic [DIM_W-1:0] window_width;
    logic [DIM_W-1:0] window_height;
    logic [LOG_W-1:0] branching_log2;
  } thb_req_t;

  typedef struct packed {
    logic [DIM_W-1:0]    level_width;
    logic [DIM_W-1:0]    level_height;
    logic [DIM_W-1:0]    tiles_across;
    logic [DIM_W-1:0]    tiles_down;
    logic [TILE_W-1:0]   tile_width;
    logic [TILE_W-1:0]   tile_height;
    logic [PX_W-1:0]     tile_pixels_x;
    logic [PX_W-1:0]     tile_pixels_y;
    logic [BORDER_W-1:0] border_pixels_x;
    logic [BORDER_W-1:0] border_pixels_y;
    logic                is_last;
  } thb_lvl_t;

  typedef struct packed {
    logic [DIM_W-1:0] lw;
    logic [DIM_W-1:0] lh;
    logic [DIM_W-1:0] tx;
    logic [DIM_W-1:0] ty;
  } thb_size_t;

  typedef struct packed {
    logic [LOG_W-1:0]    ltw;
    logic [LOG_W-1:0]    lth;
    logic [EXP_W-1:0]    ex;
    logic [EXP_W-1:0]    ey;
    logic [BORDER_W-1:0] bx;
    logic [BORDER_W-1:0] by;
  } thb_tile_t;

  typedef struct packed {
    logic load;
    logic step_x;
    logic step_y;
    logic record;
    logic emit_ld;
  } thb_cmd_t;

  typedef struct packed {
    logic more;
    logic need_x;
    logic need_y;
    logic last_idx;
    logic out_free;
  } thb_stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REBAL_X,
    S_REBAL_Y,
    S_RECORD,
    S_EMIT_RD,
    S_EMIT_LD
  } thb_state_t;

endpackage
`default_nettype wire

[hdl/thb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module thb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[hdl/thb_ctrl.sv]
// Sequencer of the tile hierarchy builder: rebalance, record, emit.
// Depends on thb_pkg.
`default_nettype none
module thb_ctrl
  import thb_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  output logic           req_ready,
  input  wire thb_stat_t stat,
  output thb_cmd_t       cmd
);

  thb_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_REBAL_X;
        end
      end
      S_REBAL_X: begin
        if (stat.need_x) begin
          cmd.step_x = 1'b1;
        end else begin
          state_next = S_REBAL_Y;
        end
      end
      S_REBAL_Y: begin
        if (stat.need_y) begin
          cmd.step_y = 1'b1;
        end else begin
          state_next = S_RECORD;
        end
      end
      S_RECORD: begin
        cmd.record = 1'b1;
        state_next = stat.more ? S_REBAL_X : S_EMIT_RD;
      end
      S_EMIT_RD: begin
        state_next = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (stat.out_free) begin
          cmd.emit_ld = 1'b1;
          state_next  = stat.last_idx ? S_IDLE : S_EMIT_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[hdl/thb_datapath.sv]
// Datapath of the tile hierarchy builder: level registers, level stores
// and output word register. Depends on thb_pkg and thb_ram.
`default_nettype none
module thb_datapath
  import thb_pkg::*;
#(
  parameter int unsigned MAX_LEVELS  = 32,
  parameter int unsigned WINDOW_BITS = 14
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire thb_req_t req,
  input  wire thb_cmd_t cmd,
  output thb_stat_t     stat,
  output logic          lvl_valid,
  input  wire logic     lvl_ready,
  output thb_lvl_t      lvl
);

  localparam int unsigned CAP     = (MAX_LEVELS < RESULT_LIMIT) ? MAX_LEVELS : RESULT_LIMIT;
  localparam int unsigned NW      = $clog2(CAP + 1);
  localparam int unsigned AW      = $clog2(MAX_LEVELS);
  localparam int unsigned WIN_TOP = 1 << WINDOW_BITS;

  logic [DIM_W-1:0] win_w, win_h, lw, lh;
  logic [LOG_W-1:0] ltw, lth;
  logic [EXP_W-1:0] ex, ey;
  logic [NW-1:0]    n, e;

  logic [DIM_W-1:0]  cw, ch;
  logic [LOG_W-1:0]  k, k_half;
  logic [TILE_W-1:0] tw, th;
  logic [DIM_W:0]    tx_sum, ty_sum;
  logic [EXP_W-1:0]  ex_new, ey_new;
  logic [DIM_W-1:0]  bx_full, by_full;
  thb_size_t         size_wr, size_rd;
  thb_tile_t         tile_wr, tile_rd;

  function automatic logic [DIM_W-1:0] clamp_win(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > WIN_TOP) begin
      r = DIM_W'(WIN_TOP);
    end else begin
      r = v;
    end
    return r;
  endfunction

  always_comb begin
    cw = clamp_win(req.window_width);
    ch = clamp_win(req.window_height);
    if (req.branching_log2 < BRANCH_LOG2_MIN) begin
      k = BRANCH_LOG2_MIN;
    end else if (req.branching_log2 > BRANCH_LOG2_MAX) begin
      k = BRANCH_LOG2_MAX;
    end else begin
      k = req.branching_log2;
    end
    k_half = k >> 1;
  end

  assign tw = TILE_W'(1) << ltw;
  assign th = TILE_W'(1) << lth;

  assign stat.more   = (lw != DIM_W'(1) || lh != DIM_W'(1)) &&
                       (({1'b0, n} + 1'b1) < (NW + 1)'(CAP));
  assign stat.need_x = stat.more && (lh != DIM_W'(1)) &&
                       ({5'b0, tw} >= {lw, 1'b0});
  assign stat.need_y = stat.more && (lw != DIM_W'(1)) &&
                       ({5'b0, th} >= {lh, 1'b0});
  assign stat.last_idx = (e == '0);
  assign stat.out_free = !lvl_valid || lvl_ready;

  assign tx_sum = ({1'b0, lw} + (DIM_W + 1)'(tw - 1'b1)) >> ltw;
  assign ty_sum = ({1'b0, lh} + (DIM_W + 1)'(th - 1'b1)) >> lth;
  assign ex_new = ex + EXP_W'(ltw);
  assign ey_new = ey + EXP_W'(lth);
  assign bx_full = (ex_new >= EXP_W'(DIM_W)) ? win_w : (win_w & ~({DIM_W{1'b1}} << ex_new));
  assign by_full = (ey_new >= EXP_W'(DIM_W)) ? win_h : (win_h & ~({DIM_W{1'b1}} << ey_new));

  always_comb begin
    size_wr.lw  = lw;
    size_wr.lh  = lh;
    size_wr.tx  = tx_sum[DIM_W-1:0];
    size_wr.ty  = ty_sum[DIM_W-1:0];
    tile_wr.ltw = ltw;
    tile_wr.lth = lth;
    tile_wr.ex  = ex_new;
    tile_wr.ey  = ey_new;
    tile_wr.bx  = bx_full[BORDER_W-1:0];
    tile_wr.by  = by_full[BORDER_W-1:0];
  end

  thb_ram #(.WIDTH($bits(thb_size_t)), .DEPTH(MAX_LEVELS)) u_size_ram (
    .clk   (clk),
    .we    (cmd.record),
    .waddr (AW'(n)),
    .wdata (size_wr),
    .raddr (AW'(e)),
    .rdata (size_rd)
  );

  thb_ram #(.WIDTH($bits(thb_tile_t)), .DEPTH(MAX_LEVELS)) u_tile_ram (
    .clk   (clk),
    .we    (cmd.record),
    .waddr (AW'(n)),
    .wdata (tile_wr),
    .raddr (AW'(e)),
    .rdata (tile_rd)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      win_w <= cw;
      win_h <= ch;
      lw    <= cw;
      lh    <= ch;
      lth   <= k_half;
      ltw   <= k - k_half;
      ex    <= '0;
      ey    <= '0;
    end else if (cmd.step_x) begin
      ltw <= ltw - 1'b1;
      lth <= lth + 1'b1;
    end else if (cmd.step_y) begin
      lth <= lth - 1'b1;
      ltw <= ltw + 1'b1;
    end else if (cmd.record) begin
      ex <= ex_new;
      ey <= ey_new;
      if (stat.more) begin
        lw  <= tx_sum[DIM_W-1:0];
        lh  <= ty_sum[DIM_W-1:0];
        ltw <= lth;
        lth <= ltw;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n <= '0;
      e <= '0;
    end else if (cmd.load) begin
      n <= '0;
    end else if (cmd.record) begin
      if (stat.more) begin
        n <= n + 1'b1;
      end else begin
        e <= n;
      end
    end else if (cmd.emit_ld && !stat.last_idx) begin
      e <= e - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lvl_valid <= 1'b0;
    end else if (cmd.emit_ld) begin
      lvl_valid <= 1'b1;
    end else if (lvl_ready) begin
      lvl_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_ld) begin
      lvl.level_width     <= size_rd.lw;
      lvl.level_height    <= size_rd.lh;
      lvl.tiles_across    <= size_rd.tx;
      lvl.tiles_down      <= size_rd.ty;
      lvl.tile_width      <= TILE_W'(1) << tile_rd.ltw;
      lvl.tile_height     <= TILE_W'(1) << tile_rd.lth;
      lvl.tile_pixels_x   <= PX_W'(1) << tile_rd.ex;
      lvl.tile_pixels_y   <= PX_W'(1) << tile_rd.ey;
      lvl.border_pixels_x <= tile_rd.bx;
      lvl.border_pixels_y <= tile_rd.by;
      lvl.is_last         <= stat.last_idx;
    end
  end

endmodule
`default_nettype wire

[hdl/tile_hierarchy_builder.sv]
// Per level: rebalance steps, then a record state. Per word: a read state
// and a load state that waits for the sink; up to 29 levels per request.
// Throughput: one request at a time, taken only once the last word is in
// the output register. Reset clears the sequencer, counters and output
// valid; the level stores are not cleared and each request writes them.
`default_nettype none
module tile_hierarchy_builder
  import thb_pkg::*;
#(
  parameter int unsigned MAX_LEVELS  = 32,
  parameter int unsigned WINDOW_BITS = 14
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  output logic          req_ready,
  input  wire thb_req_t req,
  output logic          lvl_valid,
  input  wire logic     lvl_ready,
  output thb_lvl_t      lvl
);

  thb_cmd_t  cmd;
  thb_stat_t stat;

  thb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  thb_datapath #(
    .MAX_LEVELS  (MAX_LEVELS),
    .WINDOW_BITS (WINDOW_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .lvl_valid (lvl_valid),
    .lvl_ready (lvl_ready),
    .lvl       (lvl)
  );

endmodule
`default_nettype wire

[hdl/thb_checker.sv]
// Port-level checks of the tile hierarchy builder, bound to the top level.
// Depends on thb_pkg and tile_hierarchy_builder_assert.svh.
`default_nettype none
`include "tile_hierarchy_builder_assert.svh"
module thb_checker
  import thb_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     req_valid,
  input wire logic     req_ready,
  input wire logic     lvl_valid,
  input wire logic     lvl_ready,
  input wire thb_lvl_t lvl
);

  logic counts_ok;

  assign counts_ok = lvl.tiles_across != '0 && lvl.tiles_down != '0 &&
                     lvl.tiles_across <= lvl.level_width &&
                     lvl.tiles_down <= lvl.level_height;

  `THB_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready)
  `THB_ASSERT_NOW(a_busy_until_last, lvl_valid && !lvl.is_last, !req_ready)
  `THB_ASSERT_NOW(a_tile_pow2, lvl_valid, $onehot(lvl.tile_width) && $onehot(lvl.tile_height))
  `THB_ASSERT_NOW(a_counts_fit, lvl_valid, counts_ok)
  `THB_ASSERT_NEXT(a_word_held, lvl_valid && !lvl_ready, lvl_valid && $stable(lvl))

endmodule

bind tile_hierarchy_builder thb_checker u_thb_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .lvl_valid (lvl_valid),
  .lvl_ready (lvl_ready),
  .lvl       (lvl)
);
`default_nettype wire

[dv/tb_tile_hierarchy_builder.sv]
// Testbench for tile_hierarchy_builder: directed and random requests, with a level predictor
// and an in-order scoreboard checking every emitted level word field by field.
// Depends on thb_pkg and the tile_hierarchy_builder RTL.
`timescale 1ns / 1ps
module tb_tile_hierarchy_builder
  import thb_pkg::*;
;

  localparam longint unsigned WIN_LIMIT = 64'd16384;
  localparam int unsigned     LEVEL_CAP = (32 < RESULT_LIMIT) ? 32 : RESULT_LIMIT;
  localparam int unsigned     N_RANDOM  = 199;

  class level_board;
    thb_lvl_t    levels_due[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    function int unsigned pending();
      return levels_due.size();
    endfunction

    // Predict every level of one request and queue them coarsest first.
    function void note_request(thb_req_t r);
      longint unsigned win_w, win_h, lw, lh, tw, th, pxw, pxh, cols, rows, swap;
      int unsigned     k, count;
      bit              go, flat_x, flat_y;
      thb_lvl_t        found[$];
      thb_lvl_t        e;
      win_w = 64'(r.window_width);
      win_h = 64'(r.window_height);
      if (win_w == 0) win_w = 1;
      if (win_w > WIN_LIMIT) win_w = WIN_LIMIT;
      if (win_h == 0) win_h = 1;
      if (win_h > WIN_LIMIT) win_h = WIN_LIMIT;
      k = 32'(r.branching_log2);
      if (k < 1) k = 1;
      if (k > 10) k = 10;
      th = 64'd1 << (k / 2);
      tw = (64'd1 << k) / th;
      lw = win_w;
      lh = win_h;
      pxw = 1;
      pxh = 1;
      count = 0;
      forever begin
        go = (lw > 1 || lh > 1) && (count + 1 < LEVEL_CAP);
        if (go) begin
          flat_x = (lw == 1);
          flat_y = (lh == 1);
          while (tw >= lw * 2 && !flat_y) begin
            tw = tw / 2;
            th = th * 2;
          end
          while (th >= lh * 2 && !flat_x) begin
            th = th / 2;
            tw = tw * 2;
          end
        end
        pxw = pxw * tw;
        pxh = pxh * th;
        cols = (lw + tw - 1) / tw;
        rows = (lh + th - 1) / th;
        e.level_width     = lw[DIM_W-1:0];
        e.level_height    = lh[DIM_W-1:0];
        e.tiles_across    = cols[DIM_W-1:0];
        e.tiles_down      = rows[DIM_W-1:0];
        e.tile_width      = tw[TILE_W-1:0];
        e.tile_height     = th[TILE_W-1:0];
        e.tile_pixels_x   = pxw[PX_W-1:0];
        e.tile_pixels_y   = pxh[PX_W-1:0];
        e.border_pixels_x = BORDER_W'(win_w % pxw);
        e.border_pixels_y = BORDER_W'(win_h % pxh);
        e.is_last         = (count == 0);
        found.insert(found.size(), e);
        count++;
        if (!go) break;
        lw = cols;
        lh = rows;
        swap = tw;
        tw = th;
        th = swap;
      end
      for (int i = found.size() - 1; i >= 0; i--) levels_due.insert(levels_due.size(), found[i]);
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_level(thb_lvl_t got);
      thb_lvl_t want;
      if (levels_due.size() == 0) begin
        $error("level word with no request pending");
        errors++;
        return;
      end
      want = levels_due.pop_front();
      compare_field("level_width", 64'(want.level_width), 64'(got.level_width));
      compare_field("level_height", 64'(want.level_height), 64'(got.level_height));
      compare_field("tiles_across", 64'(want.tiles_across), 64'(got.tiles_across));
      compare_field("tiles_down", 64'(want.tiles_down), 64'(got.tiles_down));
      compare_field("tile_width", 64'(want.tile_width), 64'(got.tile_width));
      compare_field("tile_height", 64'(want.tile_height), 64'(got.tile_height));
      compare_field("tile_pixels_x", 64'(want.tile_pixels_x), 64'(got.tile_pixels_x));
      compare_field("tile_pixels_y", 64'(want.tile_pixels_y), 64'(got.tile_pixels_y));
      compare_field("border_pixels_x", 64'(want.border_pixels_x), 64'(got.border_pixels_x));
      compare_field("border_pixels_y", 64'(want.border_pixels_y), 64'(got.border_pixels_y));
      compare_field("is_last", 64'(want.is_last), 64'(got.is_last));
    endfunction
  endclass

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_ready;
  thb_req_t req       = '0;
  logic     lvl_valid;
  logic     lvl_ready = 1'b0;
  thb_lvl_t lvl;

  level_board  board = new();
  logic [5:0]  stall_cnt  = '0;
  int unsigned stall_mode = 0;

  tile_hierarchy_builder u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .lvl_valid (lvl_valid),
    .lvl_ready (lvl_ready),
    .lvl       (lvl)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  // Sink: check accepted words, stall on a pattern that changes whenever the stall counter wraps.
  always @(posedge clk) begin
    if (!rst && lvl_valid && lvl_ready) board.check_level(lvl);
    stall_cnt <= stall_cnt + 1'b1;
    if (stall_cnt == '0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: lvl_ready <= 1'b1;
      1: lvl_ready <= 1'($urandom_range(0, 1));
      2: lvl_ready <= ($urandom_range(0, 3) == 0);
      default: lvl_ready <= (stall_cnt[3:0] == 4'd0);
    endcase
  end

  // Drive one request and hold it until taken; caller lowers valid in a gap.
  task automatic send_req(input int unsigned w, input int unsigned h,
                          input int unsigned k);
    thb_req_t item;
    item.window_width   = DIM_W'(w);
    item.window_height  = DIM_W'(h);
    item.branching_log2 = LOG_W'(k);
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (!req_ready);
    board.note_request(item);
  endtask

  task automatic idle_gap(input int unsigned cycles);
    if (cycles > 0) begin
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  function automatic int unsigned pick_window();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 25) return $urandom_range(1, 64);
    if (sel < 80) return $urandom_range(1, 16384);
    return $urandom_range(0, 32767);
  endfunction

  initial begin
    int unsigned left, burst;
    int unsigned k;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_req(1, 1, 1);
    send_req(16384, 16384, 10);
    send_req(0, 0, 0);
    send_req(32767, 32767, 15);
    idle_gap(3);
    send_req(16385, 1, 11);
    send_req(1, 16384, 2);
    send_req(16384, 1, 3);
    send_req(1920, 1080, 4);
    idle_gap(1);
    send_req(1280, 720, 5);
    send_req(3, 5, 6);
    send_req(640, 480, 7);
    send_req(2, 2, 8);
    send_req(1023, 4097, 9);
    idle_gap(7);
    send_req(17000, 0, 10);
    send_req(1, 1, 10);
    send_req(8191, 8193, 12);
    send_req(256, 256, 1);
    send_req(100, 16384, 14);
    send_req('h5555, 'h2aaa, 5);
    send_req('h2aaa, 'h5555, 10);

    left = N_RANDOM;
    while (left > 0) begin
      idle_gap($urandom_range(0, 1) ? 0 : $urandom_range(1, 30));
      burst = $urandom_range(1, 6);
      while (burst > 0 && left > 0) begin
        if ($urandom_range(0, 99) < 85) k = $urandom_range(1, 10);
        else k = $urandom_range(0, 15);
        send_req(pick_window(), pick_window(), k);
        burst--;
        left--;
      end
    end
    req_valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (board.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/thb_pkg.sv
hdl/thb_ram.sv
hdl/thb_ctrl.sv
hdl/thb_datapath.sv
hdl/tile_hierarchy_builder.sv
hdl/thb_checker.sv
dv/tb_tile_hierarchy_builder.sv
